// File: sv/rmu_pkg.sv
// ----------------------------------------------------------------------------
// rmu_pkg
// Shared constants, codes and types of the relocation modify unit.
// ----------------------------------------------------------------------------
package rmu_pkg;

  localparam int ADDR_WIDTH     = 20;
  localparam int MAX_HALF_BYTES = 6;

  localparam int MEM_DEPTH = 1 << ADDR_WIDTH;
  localparam int MAX_BYTES = (MAX_HALF_BYTES + 1) / 2;
  localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int HB_W      = $clog2(MAX_HALF_BYTES + 1);
  localparam int FIELD_W   = 24;
  localparam int SYM_W     = 24;
  localparam int SUM_W     = (4 * MAX_HALF_BYTES > FIELD_W) ? 4 * MAX_HALF_BYTES : FIELD_W;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_RD,
    ST_RDW,
    ST_MRD,
    ST_MADD,
    ST_MWR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [ADDR_WIDTH-1:0] addr;
    logic [7:0]            wd;
  } mem_req_t;

endpackage

// File: sv/rmu_mem.sv
// ----------------------------------------------------------------------------
// rmu_mem
// Byte memory with one port and registered read data; sweeps every entry to
// zero after reset while it reports busy.
// ----------------------------------------------------------------------------
module rmu_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  rmu_pkg::mem_req_t req,
  output logic [7:0]        rd_data,
  output logic              busy
);

  logic [7:0]                    mem [rmu_pkg::MEM_DEPTH];
  logic                          clr_active_r;
  logic                          clr_active_nxt;
  logic [rmu_pkg::ADDR_WIDTH-1:0] clr_addr_r;
  logic [rmu_pkg::ADDR_WIDTH-1:0] clr_addr_nxt;
  logic                          we;
  logic [rmu_pkg::ADDR_WIDTH-1:0] addr;
  logic [7:0]                    wd;
  logic [7:0]                    rd_data_r;

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (&clr_addr_r) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  assign we   = clr_active_r | req.we;
  assign addr = clr_active_r ? clr_addr_r : req.addr;
  assign wd   = clr_active_r ? 8'h00 : req.wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wd;
    end
    rd_data_r <= mem[addr];
  end

  assign rd_data = rd_data_r;
  assign busy    = clr_active_r;

endmodule

// File: sv/relocation_modify_unit.sv
// ----------------------------------------------------------------------------
// relocation_modify_unit
// Byte memory with write, read and relocation-modify commands; a modify
// reads a field of 1 to 6 nibbles, adds or subtracts a symbol value and
// writes the field back.
// ----------------------------------------------------------------------------
// channel | direction | beat
// in_     | input     | command, address, write_byte, half_bytes, subtract,
//         |           | symbol_value
// out_    | output    | read_byte, field_value
//
// a write passes ST_WR and ST_DONE, a read ST_RD, ST_RDW and ST_DONE; an
// unused command or zero length goes to ST_DONE; a modify reads the field
// bytes in ST_MRD, updates in ST_MADD and writes back in ST_MWR; the
// single memory port does one byte read or write per cycle; after reset the
// memory (2^ADDR_WIDTH bytes) is cleared one byte per cycle with in_stall high
// the result sits in an output register, so the next beat is taken while
// the previous result waits on out_stall
// ----------------------------------------------------------------------------
module relocation_modify_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_command,
  input  logic [rmu_pkg::ADDR_WIDTH-1:0] in_address,
  input  logic [7:0]                     in_write_byte,
  input  logic [2:0]                     in_half_bytes,
  input  logic                           in_subtract,
  input  logic [rmu_pkg::SYM_W-1:0]      in_symbol_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_read_byte,
  output logic [rmu_pkg::FIELD_W-1:0]    out_field_value
);

  localparam int AW = rmu_pkg::ADDR_WIDTH;
  localparam int SW = rmu_pkg::SUM_W;

  rmu_pkg::state_t   state_r;
  rmu_pkg::state_t   state_nxt;
  rmu_pkg::mem_req_t mem_req;
  logic [7:0]        mem_q;
  logic              mem_busy;

  logic                      in_accept;
  logic                      out_free;
  logic [3:0]                hb_sat;
  logic [1:0]                cmd_r;
  logic [AW-1:0]             addr_r;
  logic [7:0]                wbyte_r;
  logic [rmu_pkg::HB_W-1:0]  hb_r;
  logic                      odd_r;
  logic                      sub_r;
  logic [rmu_pkg::SYM_W-1:0] sym_r;
  logic [rmu_pkg::IDX_W-1:0] idx_r;
  logic [rmu_pkg::IDX_W-1:0] nb_last_r;
  logic                      rd_pend_r;
  logic                      first_pend_r;
  logic [3:0]                hi_r;
  logic [SW-1:0]             val_r;
  logic [SW-1:0]             cap_val;
  logic [SW-1:0]             sum;
  logic [SW-1:0]             mask;
  logic [SW-1:0]             new_val;
  logic [7:0]                rd_r;
  logic [rmu_pkg::FIELD_W-1:0] fv_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [7:0]                out_read_byte_r;
  logic [rmu_pkg::FIELD_W-1:0] out_field_value_r;

  rmu_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_q),
    .busy    (mem_busy)
  );

  assign in_stall  = mem_busy | (state_r != rmu_pkg::ST_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;

  assign hb_sat = ({1'b0, in_half_bytes} > 4'(rmu_pkg::MAX_HALF_BYTES)) ?
                  4'(rmu_pkg::MAX_HALF_BYTES) : {1'b0, in_half_bytes};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rmu_pkg::ST_IDLE: begin
        if (in_accept) begin
          unique case (in_command)
            rmu_pkg::CMD_WRITE:  state_nxt = rmu_pkg::ST_WR;
            rmu_pkg::CMD_READ:   state_nxt = rmu_pkg::ST_RD;
            rmu_pkg::CMD_MODIFY: state_nxt = (hb_sat == 4'd0) ? rmu_pkg::ST_DONE :
                                                                rmu_pkg::ST_MRD;
            default:             state_nxt = rmu_pkg::ST_DONE;
          endcase
        end
      end
      rmu_pkg::ST_WR:   state_nxt = rmu_pkg::ST_DONE;
      rmu_pkg::ST_RD:   state_nxt = rmu_pkg::ST_RDW;
      rmu_pkg::ST_RDW:  state_nxt = rmu_pkg::ST_DONE;
      rmu_pkg::ST_MRD:  state_nxt = (idx_r == nb_last_r) ? rmu_pkg::ST_MADD : rmu_pkg::ST_MRD;
      rmu_pkg::ST_MADD: state_nxt = rmu_pkg::ST_MWR;
      rmu_pkg::ST_MWR:  state_nxt = (idx_r == '0) ? rmu_pkg::ST_DONE : rmu_pkg::ST_MWR;
      rmu_pkg::ST_DONE: state_nxt = out_free ? rmu_pkg::ST_IDLE : rmu_pkg::ST_DONE;
      default:          state_nxt = rmu_pkg::ST_IDLE;
    endcase
  end

  // memory port
  always_comb begin
    mem_req.we   = 1'b0;
    mem_req.addr = addr_r + AW'(idx_r);
    mem_req.wd   = val_r[7:0];
    unique case (state_r)
      rmu_pkg::ST_WR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = addr_r;
        mem_req.wd   = wbyte_r;
      end
      rmu_pkg::ST_MWR: begin
        mem_req.we = 1'b1;
        if (idx_r == '0 && odd_r) begin
          mem_req.wd = {hi_r, val_r[3:0]};
        end
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  // field assembly and update
  always_comb begin
    if (first_pend_r) begin
      cap_val = odd_r ? SW'(mem_q[3:0]) : SW'(mem_q);
    end else begin
      cap_val = {val_r[SW-9:0], mem_q};
    end
    sum     = sub_r ? (cap_val - SW'(sym_r)) : (cap_val + SW'(sym_r));
    mask    = ~({SW{1'b1}} << {hb_r, 2'b00});
    new_val = sum & mask;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == rmu_pkg::ST_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rmu_pkg::ST_IDLE;
      out_valid_r  <= 1'b0;
      rd_pend_r    <= 1'b0;
      first_pend_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_pend_r    <= (state_r == rmu_pkg::ST_MRD);
      first_pend_r <= (state_r == rmu_pkg::ST_MRD) && (idx_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r     <= in_command;
      addr_r    <= in_address;
      wbyte_r   <= in_write_byte;
      hb_r      <= rmu_pkg::HB_W'(hb_sat);
      odd_r     <= hb_sat[0];
      sub_r     <= in_subtract;
      sym_r     <= in_symbol_value;
      idx_r     <= '0;
      nb_last_r <= rmu_pkg::IDX_W'((hb_sat - 4'd1) >> 1);
      rd_r      <= '0;
      fv_r      <= '0;
    end
    if (rd_pend_r && state_r == rmu_pkg::ST_MRD) begin
      val_r <= cap_val;
    end
    if (first_pend_r) begin
      hi_r <= mem_q[7:4];
    end
    unique case (state_r)
      rmu_pkg::ST_RDW: begin
        rd_r <= mem_q;
      end
      rmu_pkg::ST_MRD: begin
        if (idx_r != nb_last_r) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      rmu_pkg::ST_MADD: begin
        val_r <= new_val;
        fv_r  <= new_val[rmu_pkg::FIELD_W-1:0];
      end
      rmu_pkg::ST_MWR: begin
        val_r <= val_r >> 8;
        if (idx_r != '0) begin
          idx_r <= idx_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (state_r == rmu_pkg::ST_DONE && out_free) begin
      out_read_byte_r   <= rd_r;
      out_field_value_r <= fv_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_byte   = out_read_byte_r;
  assign out_field_value = out_field_value_r;

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmu_pkg::ST_IDLE) |-> !mem_req.we)
    else $error("memory write while idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == rmu_pkg::ST_DONE))
    else $error("result raised outside done state");

  a_idx_in_field: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmu_pkg::ST_MRD || state_r == rmu_pkg::ST_MWR) |-> (idx_r <= nb_last_r))
    else $error("byte index beyond field");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_read_byte_r != 8'h00) |-> (out_field_value_r == '0))
    else $error("read and modify results both set");

  a_mod_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmu_pkg::ST_MADD) |-> (cmd_r == rmu_pkg::CMD_MODIFY && rd_pend_r))
    else $error("field update without modify read");
`endif

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the relocation modify unit. A directed table covers
// memory extremes, address wrap, zero and overlong field lengths and the
// unused command; a random stream of all four commands on a few busy address
// windows follows. Every result beat is checked against a typed row's fixed
// result or an in-bench byte memory model, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int AW = rmu_pkg::ADDR_WIDTH;
  localparam int SW = rmu_pkg::SYM_W;
  localparam int FW = rmu_pkg::FIELD_W;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 3;
  localparam int RANDOM_BEATS = 1100;
  localparam int PHASES       = 4;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int CYCLE_LIMIT  = 4 * rmu_pkg::MEM_DEPTH + 1000000;
  localparam int DIRECTED_N   = 24;

  typedef struct packed {
    logic [1:0]    command;
    logic [AW-1:0] address;
    logic [7:0]    write_byte;
    logic [2:0]    half_bytes;
    logic          subtract;
    logic [SW-1:0] symbol_value;
  } beat_t;

  typedef struct packed {
    logic [7:0]    read_byte;
    logic [FW-1:0] field_value;
  } result_t;

  typedef struct packed {
    beat_t   beat;
    logic    typed;
    result_t res;
  } stim_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    in_command = '0;
  logic [AW-1:0] in_address = '0;
  logic [7:0]    in_write_byte = '0;
  logic [2:0]    in_half_bytes = '0;
  logic          in_subtract = 1'b0;
  logic [SW-1:0] in_symbol_value = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [7:0]    out_read_byte;
  logic [FW-1:0] out_field_value;

  logic [7:0] mem_image [rmu_pkg::MEM_DEPTH];
  result_t    expected_results [$];
  stim_row_t  directed_rows [DIRECTED_N];
  logic       no_idle = 1'b0;
  int         error_count = 0;
  int         cycle_count = 0;
  int         out_stall_left = 0;

  relocation_modify_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_address      (in_address),
    .in_write_byte   (in_write_byte),
    .in_half_bytes   (in_half_bytes),
    .in_subtract     (in_subtract),
    .in_symbol_value (in_symbol_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_byte   (out_read_byte),
    .out_field_value (out_field_value)
  );

  always #5 clk = ~clk;

  // applies one beat to the memory image and returns the result it causes
  function automatic result_t relocate_beat(beat_t b);
    result_t       r;
    int            hb;
    int            nbytes;
    int            i;
    logic [AW-1:0] a;
    logic [63:0]   field;
    logic [63:0]   mask;
    logic [7:0]    field_byte;
    r = '0;
    case (b.command)
      rmu_pkg::CMD_WRITE: mem_image[b.address] = b.write_byte;
      rmu_pkg::CMD_READ:  r.read_byte = mem_image[b.address];
      rmu_pkg::CMD_MODIFY: begin
        hb = int'(b.half_bytes);
        if (hb > rmu_pkg::MAX_HALF_BYTES) hb = rmu_pkg::MAX_HALF_BYTES;
        if (hb != 0) begin
          nbytes = (hb + 1) / 2;
          field = '0;
          for (i = 0; i < nbytes; i++) begin
            a = b.address + AW'(i);
            if (i == 0 && hb % 2 == 1) field = {field[59:0], mem_image[a][3:0]};
            else field = {field[55:0], mem_image[a]};
          end
          mask = (64'd1 << (4 * hb)) - 64'd1;
          if (b.subtract) field = (field - 64'(b.symbol_value)) & mask;
          else field = (field + 64'(b.symbol_value)) & mask;
          for (i = 0; i < nbytes; i++) begin
            a = b.address + AW'(i);
            field_byte = 8'(field >> (8 * (nbytes - 1 - i)));
            if (i == 0 && hb % 2 == 1) mem_image[a] = {mem_image[a][7:4], field_byte[3:0]};
            else mem_image[a] = field_byte;
          end
          r.field_value = field[FW-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic int sender_gap_len();
    if (no_idle || $urandom_range(0, 99) < 55) return 0;
    return pick_gap();
  endfunction

  function automatic beat_t random_beat(logic [AW-1:0] hot_base);
    beat_t b;
    int    pick;
    b.write_byte   = 8'($urandom);
    b.subtract     = 1'($urandom);
    b.symbol_value = SW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) b.command = rmu_pkg::CMD_MODIFY;
    else if (pick < 70) b.command = rmu_pkg::CMD_WRITE;
    else if (pick < 95) b.command = rmu_pkg::CMD_READ;
    else b.command = CMD_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick == 0) b.address = AW'($urandom);
    else if (pick < 3) b.address = AW'(rmu_pkg::MEM_DEPTH - 8 + $urandom_range(0, 15));
    else b.address = hot_base + AW'($urandom_range(0, 63));
    if ($urandom_range(0, 19) == 0) b.half_bytes = ($urandom_range(0, 1) != 0) ? 3'd7 : 3'd0;
    else b.half_bytes = 3'($urandom_range(1, 6));
    return b;
  endfunction

  task automatic send_beat(beat_t b, logic typed, result_t typed_res);
    result_t predicted;
    in_valid        <= 1'b1;
    in_command      <= b.command;
    in_address      <= b.address;
    in_write_byte   <= b.write_byte;
    in_half_bytes   <= b.half_bytes;
    in_subtract     <= b.subtract;
    in_symbol_value <= b.symbol_value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = relocate_beat(b);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic sender_idle(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  initial begin
    logic [AW-1:0] hot_base;
    int            k;
    int            n;
    for (k = 0; k < rmu_pkg::MEM_DEPTH; k++) mem_image[k] = '0;
    directed_rows = '{
      '{'{rmu_pkg::CMD_READ,   20'h00000, 8'h00, 3'd0, 1'b0, 24'h000000},
        1'b1, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_READ,   20'hFFFFF, 8'h00, 3'd0, 1'b0, 24'h000000},
        1'b1, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_WRITE,  20'h00000, 8'hFF, 3'd0, 1'b0, 24'h000000},
        1'b1, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_WRITE,  20'hFFFFF, 8'hA5, 3'd0, 1'b0, 24'h000000},
        1'b1, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_READ,   20'hFFFFF, 8'h00, 3'd0, 1'b0, 24'h000000},
        1'b1, '{8'hA5, 24'h000000}},
      '{'{rmu_pkg::CMD_READ,   20'h00000, 8'h00, 3'd0, 1'b0, 24'h000000},
        1'b1, '{8'hFF, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'hFFFFF, 8'h00, 3'd6, 1'b0, 24'h000001},
        1'b1, '{8'h00, 24'hA5FF01}},
      '{'{rmu_pkg::CMD_MODIFY, 20'hFFFFF, 8'h00, 3'd5, 1'b1, 24'hFFFFFF},
        1'b0, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'h00010, 8'hFF, 3'd0, 1'b1, 24'hFFFFFF},
        1'b1, '{8'h00, 24'h000000}},
      '{'{CMD_UNUSED,          20'hFFFFF, 8'hFF, 3'd7, 1'b1, 24'hFFFFFF},
        1'b1, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_WRITE,  20'h55555, 8'h00, 3'd7, 1'b1, 24'hFFFFFF},
        1'b1, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_READ,   20'hAAAAA, 8'hFF, 3'd7, 1'b1, 24'hFFFFFF},
        1'b1, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'h00000, 8'h00, 3'd1, 1'b0, 24'hFFFFFF},
        1'b0, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_READ,   20'h00000, 8'h00, 3'd0, 1'b0, 24'h000000},
        1'b0, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'h12345, 8'h00, 3'd6, 1'b1, 24'h000000},
        1'b1, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'h12345, 8'h00, 3'd6, 1'b1, 24'h000001},
        1'b1, '{8'h00, 24'hFFFFFF}},
      '{'{rmu_pkg::CMD_READ,   20'h12345, 8'h00, 3'd0, 1'b0, 24'h000000},
        1'b1, '{8'hFF, 24'h000000}},
      '{'{rmu_pkg::CMD_READ,   20'h12347, 8'h00, 3'd0, 1'b0, 24'h000000},
        1'b1, '{8'hFF, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'h12345, 8'h00, 3'd7, 1'b0, 24'h000001},
        1'b1, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'h12346, 8'h00, 3'd3, 1'b0, 24'hABCDEF},
        1'b0, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'h12346, 8'h00, 3'd4, 1'b1, 24'h123456},
        1'b0, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'h12346, 8'h00, 3'd2, 1'b0, 24'h0000FF},
        1'b0, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_READ,   20'h12346, 8'h00, 3'd0, 1'b0, 24'h000000},
        1'b0, '{8'h00, 24'h000000}},
      '{'{rmu_pkg::CMD_MODIFY, 20'hFFFFE, 8'h00, 3'd6, 1'b0, 24'h000000},
        1'b0, '{8'h00, 24'h000000}}
    };
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (k = 0; k < DIRECTED_N; k++) begin
      send_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].res);
      sender_idle(sender_gap_len());
    end
    wait_for_results();

    // random stream, one busy window per phase, back to back in one phase
    for (k = 0; k < PHASES; k++) begin
      hot_base = AW'($urandom);
      no_idle  = (k == 2);
      for (n = 0; n < RANDOM_BEATS / PHASES; n++) begin
        send_beat(random_beat(hot_base), 1'b0, '0);
        sender_idle(sender_gap_len());
      end
      if (k == 1) wait_for_results();
    end
    no_idle = 1'b0;

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (out_stall_left == 0 && !no_idle && $urandom_range(0, 99) < 25)
      out_stall_left = pick_gap();
    if (out_stall_left > 0) begin
      out_stall <= 1'b1;
      out_stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result beat check
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", '0, {out_read_byte, out_field_value});
      end else begin
        want = expected_results.pop_front();
        if (out_read_byte !== want.read_byte)
          report_mismatch("read_byte", 32'(want.read_byte), 32'(out_read_byte));
        if (out_field_value !== want.field_value)
          report_mismatch("field_value", 32'(want.field_value), 32'(out_field_value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

// File: relocation_modify_unit.f
sv/rmu_pkg.sv
sv/rmu_mem.sv
sv/relocation_modify_unit.sv
tb/tb.sv
